FILE: hdl/fenbb_pkg.sv
// ----------------------------------------------------------------------------
// fenbb_pkg
// Types, character codes and decode helpers for the FEN bitboard parser.
// ----------------------------------------------------------------------------
package fenbb_pkg;

  // Parse phases
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_PLACE  = 3'd1;
  localparam logic [2:0] PH_SIDE   = 3'd2;
  localparam logic [2:0] PH_GAP    = 3'd3;
  localparam logic [2:0] PH_CASTLE = 3'd4;
  localparam logic [2:0] PH_EPSP   = 3'd5;
  localparam logic [2:0] PH_EPRANK = 3'd6;

  // Board counts and indexes
  localparam int unsigned NUM_PIECES = 12;
  localparam logic [3:0]  IDX_WHITE  = 4'd12;
  localparam logic [3:0]  IDX_BLACK  = 4'd13;
  localparam logic [3:0]  IDX_ALL    = 4'd14;

  // Square counter saturation limit
  localparam logic [3:0] POS_LIMIT = 4'd8;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_W  = 8'h77;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_UP_Q  = 8'h51;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LO_K  = 8'h6B;
  localparam logic [7:0] CH_LO_Q  = 8'h71;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_P  = 8'h70;

  // Piece letter decode result
  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } piece_t;

  function automatic piece_t piece_decode(input logic [7:0] c);
    piece_t p;
    p.hit  = 1'b1;
    p.slot = 4'd0;
    unique case (c)
      CH_UP_K: p.slot = 4'd0;
      CH_UP_Q: p.slot = 4'd1;
      CH_UP_R: p.slot = 4'd2;
      CH_UP_B: p.slot = 4'd3;
      CH_UP_N: p.slot = 4'd4;
      CH_UP_P: p.slot = 4'd5;
      CH_LO_K: p.slot = 4'd6;
      CH_LO_Q: p.slot = 4'd7;
      CH_LO_R: p.slot = 4'd8;
      CH_LO_B: p.slot = 4'd9;
      CH_LO_N: p.slot = 4'd10;
      CH_LO_P: p.slot = 4'd11;
      default: p.hit  = 1'b0;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/fen_to_bitboard_parser_top.sv
// ----------------------------------------------------------------------------
// fen_to_bitboard_parser_top
// Parses FEN text, one character per transaction, into twelve piece
// bitboards plus side, castling and en passant fields, then emits a burst
// of fifteen boards.
// ----------------------------------------------------------------------------
//  channel      handshake                      payload
//  -----------  -----------------------------  --------------------------------
//  text in      in_valid_i / in_stall_o        text_char_i
//  boards out   out_valid_o / out_stall_i      board_index_o .. last_board_o
//  config       prefix_skip_we_i               prefix_skip_i
//
//  One character is taken per cycle; parser state updates at the edge it is
//  accepted. The end-of-command character copies the boards into an output
//  buffer, which then presents fifteen transactions, one per cycle when the
//  sink does not stall. Parsing of the next command carries on during the
//  burst; input stalls only if it reaches the en passant field while the
//  buffer still holds boards. Reset clears all parser and output control.
// ----------------------------------------------------------------------------
module fen_to_bitboard_parser_top import fenbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              prefix_skip_we_i,
  input  logic [4:0]        prefix_skip_i,
  // text input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_char_i,
  // board output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        board_index_o,
  output logic [63:0]       board_bits_o,
  output logic              white_to_move_o,
  output logic              castle_white_short_o,
  output logic              castle_white_long_o,
  output logic              castle_black_short_o,
  output logic              castle_black_long_o,
  output logic              passant_valid_o,
  output logic signed [3:0] passant_file_o,
  output logic signed [3:0] passant_rank_o,
  output logic              last_board_o
);

  // Header fields carried with every board
  typedef struct packed {
    logic       side;
    logic [3:0] castle;
    logic       ep_flag;
    logic [3:0] ep_file;
    logic [3:0] ep_rank;
  } header_t;

  logic [4:0]  prefix_skip_q;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  skip_cnt_q, skip_cnt_d;
  logic [3:0]  file_q, file_d;
  logic [3:0]  row_q, row_d;
  logic [63:0] boards_q [NUM_PIECES];
  logic [63:0] boards_d [NUM_PIECES];
  header_t     hdr_q, hdr_d;
  logic        emit;
  logic        restart;

  logic [63:0] snap_q [NUM_PIECES];
  header_t     snap_hdr_q;
  logic        out_valid_q;
  logic [3:0]  out_idx_q;
  logic [63:0] out_bits_q;
  logic [3:0]  next_idx;
  logic [63:0] next_bits;
  logic [63:0] snap_white, snap_black;

  logic        in_fire, out_fire;

  // Stall only when a command could end while the buffer is still busy
  assign in_stall_o = out_valid_q && (phase_q == PH_EPSP || phase_q == PH_EPRANK);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_skip_q <= 5'd13;
    end else if (prefix_skip_we_i) begin
      prefix_skip_q <= prefix_skip_i;
    end
  end

  // Placement field step
  piece_t      pc;
  logic [4:0]  adv;
  logic [4:0]  file_sum;
  logic [5:0]  sq;
  logic        place;

  always_comb begin
    pc       = piece_decode(text_char_i);
    adv      = 5'd1;
    if (!pc.hit && text_char_i >= CH_ONE && text_char_i <= CH_EIGHT) begin
      adv = {1'b0, text_char_i[3:0]};
    end
    file_sum = {1'b0, file_q} + adv;
    sq       = {~row_q[2:0], file_q[2:0]};
    place    = 1'b0;

    phase_d    = phase_q;
    skip_cnt_d = skip_cnt_q;
    file_d     = file_q;
    row_d      = row_q;
    boards_d   = boards_q;
    hdr_d      = hdr_q;
    emit       = 1'b0;
    restart    = 1'b0;

    unique case (phase_q)
      PH_PREFIX: begin
        if (skip_cnt_q < prefix_skip_q) begin
          skip_cnt_d = skip_cnt_q + 5'd1;
        end else begin
          place = 1'b1;
        end
      end
      PH_PLACE: place = 1'b1;
      PH_SIDE: begin
        if (text_char_i != CH_SPACE) begin
          hdr_d.side = (text_char_i == CH_LO_W);
          phase_d    = PH_GAP;
        end
      end
      PH_GAP: phase_d = PH_CASTLE;
      PH_CASTLE: begin
        priority case (text_char_i)
          CH_SPACE: phase_d          = PH_EPSP;
          CH_UP_K:  hdr_d.castle[0]  = 1'b1;
          CH_UP_Q:  hdr_d.castle[1]  = 1'b1;
          CH_LO_K:  hdr_d.castle[2]  = 1'b1;
          CH_LO_Q:  hdr_d.castle[3]  = 1'b1;
          default: ;
        endcase
      end
      PH_EPSP: begin
        if (text_char_i == CH_DASH) begin
          emit = 1'b1;
        end else if (text_char_i != CH_SPACE) begin
          hdr_d.ep_flag = 1'b1;
          hdr_d.ep_file = (text_char_i >= CH_LO_A && text_char_i <= CH_LO_H) ?
                          {1'b0, text_char_i[2:0] - 3'd1} : 4'hF;
          phase_d       = PH_EPRANK;
        end
      end
      PH_EPRANK: begin
        hdr_d.ep_rank = (text_char_i >= CH_ONE && text_char_i <= CH_EIGHT) ?
                        {1'b0, text_char_i[2:0] - 3'd1} : 4'hF;
        emit          = 1'b1;
      end
      // stray phase: start over without a burst
      default: restart = 1'b1;
    endcase

    // Placement character, also used for the first one after the prefix
    if (place) begin
      phase_d = PH_PLACE;
      priority if (text_char_i == CH_SPACE) begin
        phase_d = PH_SIDE;
      end else if (text_char_i == CH_SLASH) begin
        file_d = 4'd0;
        if (row_q < POS_LIMIT) row_d = row_q + 4'd1;
      end else begin
        if (pc.hit && file_q < POS_LIMIT && row_q < POS_LIMIT) begin
          boards_d[pc.slot] = boards_q[pc.slot] | (64'd1 << sq);
        end
        file_d = (file_sum > {1'b0, POS_LIMIT}) ? POS_LIMIT : file_sum[3:0];
      end
    end
  end

  // Parser state; cleared after the command ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PREFIX;
      skip_cnt_q <= 5'd0;
      file_q     <= 4'd0;
      row_q      <= 4'd0;
      hdr_q      <= '0;
      for (int i = 0; i < NUM_PIECES; i++) boards_q[i] <= 64'd0;
    end else if (in_fire) begin
      if (emit || restart) begin
        phase_q    <= PH_PREFIX;
        skip_cnt_q <= 5'd0;
        file_q     <= 4'd0;
        row_q      <= 4'd0;
        hdr_q      <= '0;
        for (int i = 0; i < NUM_PIECES; i++) boards_q[i] <= 64'd0;
      end else begin
        phase_q    <= phase_d;
        skip_cnt_q <= skip_cnt_d;
        file_q     <= file_d;
        row_q      <= row_d;
        hdr_q      <= hdr_d;
        boards_q   <= boards_d;
      end
    end
  end

  // Output buffer snapshot
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      snap_q     <= boards_q;
      snap_hdr_q <= hdr_d;
    end
  end

  // Colour unions and next board select
  always_comb begin
    snap_white = 64'd0;
    snap_black = 64'd0;
    for (int i = 0; i < 6; i++) begin
      snap_white = snap_white | snap_q[i];
      snap_black = snap_black | snap_q[i + 6];
    end
    next_idx = out_idx_q + 4'd1;
    priority if (next_idx == IDX_WHITE) begin
      next_bits = snap_white;
    end else if (next_idx == IDX_BLACK) begin
      next_bits = snap_black;
    end else if (next_idx == IDX_ALL) begin
      next_bits = snap_white | snap_black;
    end else if (next_idx < IDX_WHITE) begin
      next_bits = snap_q[next_idx];
    end else begin
      next_bits = 64'd0;
    end
  end

  // Result register and burst sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= 4'd0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= 4'd0;
    end else if (out_fire) begin
      if (out_idx_q == IDX_ALL) begin
        out_valid_q <= 1'b0;
      end else begin
        out_idx_q <= next_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_bits_q <= boards_q[0];
    end else if (out_fire && out_idx_q != IDX_ALL) begin
      out_bits_q <= next_bits;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign board_index_o        = out_idx_q;
  assign board_bits_o         = out_bits_q;
  assign white_to_move_o      = snap_hdr_q.side;
  assign castle_white_short_o = snap_hdr_q.castle[0];
  assign castle_white_long_o  = snap_hdr_q.castle[1];
  assign castle_black_short_o = snap_hdr_q.castle[2];
  assign castle_black_long_o  = snap_hdr_q.castle[3];
  assign passant_valid_o      = snap_hdr_q.ep_flag;
  assign passant_file_o       = snap_hdr_q.ep_file;
  assign passant_rank_o       = snap_hdr_q.ep_rank;
  assign last_board_o         = (out_idx_q == IDX_ALL);

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fen_to_bitboard_parser_top. It feeds FEN text one
// character per transaction and predicts the fifteen-board bursts on its own.
// Each board transaction is checked in order against the oldest prediction.
// Directed commands cover the special cases. Random commands follow under
// several sender and receiver idling mixes, with prefix changes in between.
// ----------------------------------------------------------------------------
module tb;
  import fenbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One predicted or observed board transaction
  typedef struct packed {
    logic [3:0]  idx;
    logic [63:0] bits;
    logic        wtm;
    logic        cws;
    logic        cwl;
    logic        cbs;
    logic        cbl;
    logic        epv;
    logic [3:0]  epf;
    logic [3:0]  epr;
    logic        last;
  } board_t;

  logic              clk_i;
  logic              rst_ni           = 1'b0;
  logic              prefix_skip_we_i = 1'b0;
  logic [4:0]        prefix_skip_i    = '0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [7:0]        text_char_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [3:0]        board_index_o;
  logic [63:0]       board_bits_o;
  logic              white_to_move_o;
  logic              castle_white_short_o;
  logic              castle_white_long_o;
  logic              castle_black_short_o;
  logic              castle_black_long_o;
  logic              passant_valid_o;
  logic signed [3:0] passant_file_o;
  logic signed [3:0] passant_rank_o;
  logic              last_board_o;

  // Parser shadow state
  logic [4:0]  prefix_len;
  logic [2:0]  phase;
  logic [4:0]  skipped;
  logic [4:0]  file_at;
  logic [3:0]  row_at;
  logic [63:0] piece_bb [NUM_PIECES];
  logic        side_w;
  logic [3:0]  castle_kqkq;
  logic        ep_seen;
  logic [3:0]  ep_file;
  logic [3:0]  ep_rank;

  board_t board_q [$];
  int     err_count    = 0;
  int     idle_pct     = 0;
  int     stall_pct    = 0;

  fen_to_bitboard_parser_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .prefix_skip_we_i     (prefix_skip_we_i),
    .prefix_skip_i        (prefix_skip_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .text_char_i          (text_char_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .board_index_o        (board_index_o),
    .board_bits_o         (board_bits_o),
    .white_to_move_o      (white_to_move_o),
    .castle_white_short_o (castle_white_short_o),
    .castle_white_long_o  (castle_white_long_o),
    .castle_black_short_o (castle_black_short_o),
    .castle_black_long_o  (castle_black_long_o),
    .passant_valid_o      (passant_valid_o),
    .passant_file_o       (passant_file_o),
    .passant_rank_o       (passant_rank_o),
    .last_board_o         (last_board_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Piece letter for each board slot
  function automatic logic [7:0] piece_char(input int slot);
    case (slot)
      0:       return CH_UP_K;
      1:       return CH_UP_Q;
      2:       return CH_UP_R;
      3:       return CH_UP_B;
      4:       return CH_UP_N;
      5:       return CH_UP_P;
      6:       return CH_LO_K;
      7:       return CH_LO_Q;
      8:       return CH_LO_R;
      9:       return CH_LO_B;
      10:      return CH_LO_N;
      default: return CH_LO_P;
    endcase
  endfunction

  function automatic int piece_slot_of(input logic [7:0] c);
    for (int i = 0; i < NUM_PIECES; i++) begin
      if (piece_char(i) == c) return i;
    end
    return -1;
  endfunction

  task automatic clear_parser();
    phase       = PH_PREFIX;
    skipped     = '0;
    file_at     = '0;
    row_at      = '0;
    side_w      = 1'b0;
    castle_kqkq = '0;
    ep_seen     = 1'b0;
    ep_file     = '0;
    ep_rank     = '0;
    for (int i = 0; i < NUM_PIECES; i++) piece_bb[i] = '0;
  endtask

  // Queue the fifteen boards of a finished command, then start afresh
  task automatic queue_boards();
    logic [63:0] white;
    logic [63:0] black;
    board_t      b;
    white = '0;
    black = '0;
    for (int i = 0; i < 6; i++) begin
      white |= piece_bb[i];
      black |= piece_bb[i + 6];
    end
    for (int k = 0; k <= IDX_ALL; k++) begin
      b.idx  = k[3:0];
      if (k < NUM_PIECES)    b.bits = piece_bb[k];
      else if (k == IDX_WHITE) b.bits = white;
      else if (k == IDX_BLACK) b.bits = black;
      else                   b.bits = white | black;
      b.wtm  = side_w;
      b.cws  = castle_kqkq[0];
      b.cwl  = castle_kqkq[1];
      b.cbs  = castle_kqkq[2];
      b.cbl  = castle_kqkq[3];
      b.epv  = ep_seen;
      b.epf  = ep_file;
      b.epr  = ep_rank;
      b.last = (k == IDX_ALL);
      board_q.push_back(b);
    end
    clear_parser();
  endtask

  // Placement field: pieces, digits, slashes, space ends it
  task automatic place_step(input logic [7:0] c);
    int slot;
    int adv;
    int sq;
    slot = piece_slot_of(c);
    adv  = 1;
    if (c == CH_SPACE) begin
      phase = PH_SIDE;
    end else if (c == CH_SLASH) begin
      file_at = '0;
      if (row_at < POS_LIMIT) row_at = row_at + 1'b1;
    end else begin
      if (slot >= 0) begin
        if (file_at < POS_LIMIT && row_at < POS_LIMIT) begin
          sq = 8 * (7 - int'(row_at)) + int'(file_at);
          piece_bb[slot][sq] = 1'b1;
        end
      end else if (c >= CH_ONE && c <= CH_EIGHT) begin
        adv = int'(c - CH_ZERO);
      end
      if (int'(file_at) + adv > int'(POS_LIMIT)) file_at = 5'(POS_LIMIT);
      else file_at = 5'(int'(file_at) + adv);
    end
  endtask

  // Advance the shadow parser by one accepted character
  task automatic parse_char(input logic [7:0] c);
    case (phase)
      PH_PREFIX: begin
        if (skipped < prefix_len) begin
          skipped = skipped + 1'b1;
        end else begin
          phase = PH_PLACE;
          place_step(c);
        end
      end
      PH_PLACE: place_step(c);
      PH_SIDE: begin
        if (c != CH_SPACE) begin
          side_w = (c == CH_LO_W);
          phase  = PH_GAP;
        end
      end
      PH_GAP: phase = PH_CASTLE;
      PH_CASTLE: begin
        if (c == CH_SPACE)     phase = PH_EPSP;
        else if (c == CH_UP_K) castle_kqkq[0] = 1'b1;
        else if (c == CH_UP_Q) castle_kqkq[1] = 1'b1;
        else if (c == CH_LO_K) castle_kqkq[2] = 1'b1;
        else if (c == CH_LO_Q) castle_kqkq[3] = 1'b1;
      end
      PH_EPSP: begin
        if (c == CH_DASH) begin
          queue_boards();
        end else if (c != CH_SPACE) begin
          ep_seen = 1'b1;
          ep_file = (c >= CH_LO_A && c <= CH_LO_H) ? 4'(c - CH_LO_A) : 4'hF;
          phase   = PH_EPRANK;
        end
      end
      PH_EPRANK: begin
        ep_rank = (c >= CH_ONE && c <= CH_EIGHT) ? 4'(c - CH_ONE) : 4'hF;
        queue_boards();
      end
      default: clear_parser();
    endcase
  endtask

  // Board checker
  always @(posedge clk_i) begin : board_check
    board_t want;
    board_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.idx  = board_index_o;
      got.bits = board_bits_o;
      got.wtm  = white_to_move_o;
      got.cws  = castle_white_short_o;
      got.cwl  = castle_white_long_o;
      got.cbs  = castle_black_short_o;
      got.cbl  = castle_black_long_o;
      got.epv  = passant_valid_o;
      got.epf  = passant_file_o;
      got.epr  = passant_rank_o;
      got.last = last_board_o;
      if (board_q.size() == 0) begin
        if (err_count < 10)
          $display("unexpected board transaction idx=%0d bits=%h", got.idx, got.bits);
        err_count++;
      end else begin
        want = board_q.pop_front();
        if (got !== want) begin
          if (err_count < 10) begin
            $display("board mismatch at %0t", $realtime);
            $display("  exp idx=%0d bits=%h w=%b cas=%b%b%b%b ep=%b/%h/%h last=%b",
                     want.idx, want.bits, want.wtm, want.cws, want.cwl, want.cbs,
                     want.cbl, want.epv, want.epf, want.epr, want.last);
            $display("  got idx=%0d bits=%h w=%b cas=%b%b%b%b ep=%b/%h/%h last=%b",
                     got.idx, got.bits, got.wtm, got.cws, got.cwl, got.cbs,
                     got.cbl, got.epv, got.epf, got.epr, got.last);
          end
          err_count++;
        end
      end
    end
  end

  // Send one character; entered and left at a falling edge, valid left high
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    parse_char(c);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Whatever bytes fill the command prefix
  task automatic send_prefix_noise();
    for (int i = 0; i < prefix_len; i++) send_char(8'($urandom_range(255)));
  endtask

  // Hold the sender off until every board is out, then let the block settle
  task automatic drain_boards();
    in_valid_i <= 1'b0;
    while (board_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_prefix(input logic [4:0] v);
    prefix_skip_we_i <= 1'b1;
    prefix_skip_i    <= v;
    @(negedge clk_i);
    prefix_skip_we_i <= 1'b0;
    prefix_len = v;
  endtask

  // Short command with random content and a little noise
  task automatic send_random_command();
    int n_rows;
    int rem;
    int adv;
    int pick;
    send_prefix_noise();
    n_rows = ($urandom_range(9) == 0) ? 9 : $urandom_range(1, 3);
    for (int r = 0; r < n_rows; r++) begin
      if (r > 0) send_char(CH_SLASH);
      rem = ($urandom_range(19) == 0) ? 10 : 8;
      while (rem > 0) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          adv = $urandom_range(1, (rem > 8) ? 8 : rem);
          send_char(8'(int'(CH_ZERO) + adv));
        end else if (pick < 96) begin
          adv = 1;
          send_char(piece_char($urandom_range(NUM_PIECES - 1)));
        end else begin
          adv = 1;
          send_char(8'($urandom_range(255)));
        end
        rem -= adv;
      end
    end
    send_char(CH_SPACE);
    repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0) send_char(CH_SPACE);
    // side and the dropped character after it
    pick = $urandom_range(99);
    if (pick < 45)      send_char(CH_LO_W);
    else if (pick < 90) send_char(CH_LO_B);
    else                send_char(8'($urandom_range(255)));
    send_char(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CH_SPACE);
    // castling
    if ($urandom_range(4) == 0) begin
      send_char(CH_DASH);
    end else begin
      if ($urandom_range(1)) send_char(CH_UP_K);
      if ($urandom_range(1)) send_char(CH_UP_Q);
      if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)));
      if ($urandom_range(1)) send_char(CH_LO_K);
      if ($urandom_range(1)) send_char(CH_LO_Q);
    end
    send_char(CH_SPACE);
    if ($urandom_range(3) == 0) send_char(CH_SPACE);
    // en passant
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_char(CH_DASH);
    end else if (pick < 90) begin
      send_char(8'(int'(CH_LO_A) + $urandom_range(7)));
      send_char(8'(int'(CH_ONE) + $urandom_range(7)));
    end else begin
      send_char(8'($urandom_range(255)));
      send_char(8'($urandom_range(255)));
    end
  endtask

  // Prefix at its reset length, standard opening position
  task automatic test_reset_prefix();
    send_prefix_noise();
    send_text("rnbqkbnr/pppppppp/8/8/8/8/PPPPPPPP/RNBQKBNR w KQkq -");
    drain_boards();
  endtask

  // No prefix: first character is placement text; en passant with a rank
  task automatic test_zero_prefix();
    write_prefix(5'd0);
    send_text("4k3/8/8/8/8/8/8/4K3 b - e3");
    drain_boards();
  endtask

  // Digits advance by their value, zero, nine and other bytes by one
  task automatic test_square_advance();
    send_text("0K9Q");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("n2p/1R8B/b w Kq h8");
    drain_boards();
  endtask

  // Pieces past the last file or row are dropped, counters saturate
  task automatic test_off_board();
    send_text("pppppppppR/////////Q/k b KQkq -");
    send_text("8888Kp/7P/6n1/////// w qk -");
    drain_boards();
  endtask

  // Spaces before side, odd side letters, gap byte, castling junk, bad en passant
  task automatic test_header_fields();
    send_text("K   w?Zq+Q  z9");
    send_text("k xKkQ a1");
    send_text("B w - c0");
    drain_boards();
  endtask

  // Longest prefix
  task automatic test_max_prefix();
    write_prefix(5'd31);
    send_prefix_noise();
    send_text("8/8/8/8/8/8/8/7P w - -");
    drain_boards();
  endtask

  // Random commands under each idling mix, prefix changed between phases
  task automatic test_random_commands();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 69; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      drain_boards();
      write_prefix(($urandom_range(7) == 0) ? 5'd31 : 5'($urandom_range(3)));
      send_random_command();
      drain_boards();
    end
  endtask

  // Run limit
  initial begin
    #400_000;
    $display("FAIL fen_to_bitboard_parser_top");
    $finish;
  end

  // Test sequence
  initial begin
    prefix_len = 5'd13;
    clear_parser();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_prefix();
    test_zero_prefix();
    test_square_advance();
    test_off_board();
    test_header_fields();
    test_max_prefix();
    test_random_commands();

    drain_boards();
    repeat (40) @(negedge clk_i);
    if (err_count == 0 && board_q.size() == 0) begin
      $display("PASS fen_to_bitboard_parser_top");
    end else begin
      $display("FAIL fen_to_bitboard_parser_top");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fenbb_pkg.sv
hdl/fen_to_bitboard_parser_top.sv
tb/sv/tb.sv
